@@ src/wstq_pkg.sv @@
// Shared types and constants for the work-stealing task queue block.
`default_nettype none
package wstq_pkg;

    localparam int NUM_WORKERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ADDR_BITS_DEF   = 48;

    localparam int OPCODE_W   = 2;
    localparam int WORKER_W   = 4;
    localparam int TADDR_W    = 48;
    localparam int TSIZE_W    = 31;
    localparam int CFG_W      = 5;
    localparam int INFLIGHT_W = 11;

    localparam logic [CFG_W-1:0]      NUM_WORKERS_RST = 5'd16;
    localparam logic [INFLIGHT_W-1:0] INFLIGHT_MAX    = 11'd2047;

    localparam logic [OPCODE_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TAKE     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_COMPLETE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_PTR,
        S_ACCESS,
        S_DATA,
        S_RESULT
    } t_state;

endpackage
`default_nettype wire

@@ src/work_stealing_task_queues.sv @@
// Work-stealing task scheduler: one ring deque of tasks per worker.
//
// Requests enter on the input channel (i_in_valid / o_in_ready): push a task
// to the worker's deque tail, take a task (own tail, else steal from the head
// of the next non-empty active deque), or mark a task completed. Each request
// yields exactly one result beat on the output channel (o_out_valid /
// i_out_ready). num_workers is written through i_cfg_we / i_cfg_data; the user
// must write it only while idle, the block does not enforce this. One request
// at a time: look-up, pointer read and access, then a data read for a take; a
// steal first scans the other deques. The scan sequencer steps one deque a
// cycle; pointers and task data sit in memories with registered reads, one
// access per cycle each. A complete goes from look-up straight to the result.
// The result is held until taken; a new request is accepted the cycle after.
// Reset empties every deque and clears the in-flight count; task memory is
// not cleared and needs no clearing pass.
`default_nettype none
module work_stealing_task_queues #(
    parameter int NUM_WORKERS = wstq_pkg::NUM_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_BITS   = wstq_pkg::ADDR_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wstq_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [wstq_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [wstq_pkg::WORKER_W-1:0] i_worker,
    input  wire logic [wstq_pkg::TADDR_W-1:0]  i_task_addr,
    input  wire logic [wstq_pkg::TSIZE_W-1:0]  i_task_size,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_ok,
    output logic                               o_full_res,
    output logic [wstq_pkg::TADDR_W-1:0]       o_got_addr,
    output logic [wstq_pkg::TSIZE_W-1:0]       o_got_size,
    output logic                               o_stolen,
    output logic [wstq_pkg::WORKER_W-1:0]      o_victim,
    output logic                               o_all_done
);
    import wstq_pkg::*;

    localparam int WBITS  = $clog2(NUM_WORKERS);
    localparam int IDXW   = (WBITS > CFG_W) ? WBITS : CFG_W;
    localparam int SLW    = $clog2(QUEUE_DEPTH);
    localparam int PTRW   = SLW + 1;
    localparam int WRAP   = 2 * QUEUE_DEPTH;
    localparam int NSLOTS = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADRW   = $clog2(NSLOTS);
    localparam int SABITS = (ADDR_BITS < TADDR_W) ? ADDR_BITS : TADDR_W;

    localparam logic [PTRW-1:0] QD_P   = PTRW'(QUEUE_DEPTH);
    localparam logic [PTRW-1:0] LAST_P = PTRW'(WRAP - 1);
    localparam logic [PTRW:0]   QD_O   = (PTRW+1)'(QUEUE_DEPTH);
    localparam logic [PTRW:0]   WRAP_O = (PTRW+1)'(WRAP);
    localparam logic [6:0]      NW7    = 7'(NUM_WORKERS);

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTRW-1:0] ptr_dec(input logic [PTRW-1:0] p);
        return (p == '0) ? LAST_P : p - 1'b1;
    endfunction

    function automatic logic [ADRW-1:0] slot_addr(input logic [WBITS-1:0] w,
                                                  input logic [PTRW-1:0]  p);
        logic [SLW-1:0] s;
        s = (p >= QD_P) ? SLW'(p - QD_P) : SLW'(p);
        return ADRW'(w) * ADRW'(QUEUE_DEPTH) + ADRW'(s);
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_num_workers;
    logic [OPCODE_W-1:0]   r_op, n_op;
    logic [WORKER_W-1:0]   r_w, n_w;
    logic [SABITS-1:0]     r_taddr, n_taddr;
    logic [TSIZE_W-1:0]    r_tsize, n_tsize;
    logic [WBITS-1:0]      r_sel, n_sel;
    logic [IDXW-1:0]       r_v, n_v;
    logic [IDXW-1:0]       r_cnt, n_cnt;
    logic                  r_steal, n_steal;
    logic                  r_ok, n_ok;
    logic                  r_full, n_full;
    logic [TADDR_W-1:0]    r_got_addr, n_got_addr;
    logic [TSIZE_W-1:0]    r_got_size, n_got_size;
    logic                  r_stolen, n_stolen;
    logic [WORKER_W-1:0]   r_victim, n_victim;
    logic [INFLIGHT_W-1:0] r_in_flight, n_in_flight;
    logic [NUM_WORKERS-1:0] r_nonempty, n_nonempty;
    logic [NUM_WORKERS-1:0] r_pvalid;

    logic [2*PTRW-1:0] r_ptr_mem [NUM_WORKERS];
    logic [2*PTRW-1:0] r_ptr_q;
    logic              r_pv_q;
    logic [SABITS-1:0]  r_addr_mem [NSLOTS];
    logic [TSIZE_W-1:0] r_size_mem [NSLOTS];
    logic [SABITS-1:0]  r_rd_addr;
    logic [TSIZE_W-1:0] r_rd_size;

    logic [CFG_W-1:0] n_eff;
    logic [IDXW-1:0]  n_ext;
    logic [IDXW-1:0]  w_ext;
    logic             live;
    logic             accept;
    logic [PTRW-1:0]  head, tail, nhead, ntail;
    logic [PTRW:0]    occ;
    logic             ptr_we;
    logic [2*PTRW-1:0] ptr_wdata;
    logic             dat_we, dat_re;
    logic [ADRW-1:0]  dat_idx;

    // effective worker count: 0 acts as 1, clamp to NUM_WORKERS
    always_comb begin
        if (r_num_workers == '0) begin
            n_eff = CFG_W'(1);
        end else if ({2'b00, r_num_workers} > NW7) begin
            n_eff = NW7[CFG_W-1:0];
        end else begin
            n_eff = r_num_workers;
        end
    end

    assign n_ext  = IDXW'(n_eff);
    assign w_ext  = IDXW'(r_w);
    assign live   = w_ext < n_ext;
    assign accept = i_in_valid && o_in_ready;

    assign head  = r_pv_q ? r_ptr_q[2*PTRW-1:PTRW] : '0;
    assign tail  = r_pv_q ? r_ptr_q[PTRW-1:0] : '0;
    assign nhead = ptr_inc(head);
    assign ntail = ptr_dec(tail);
    assign occ   = (tail >= head) ? {1'b0, tail} - {1'b0, head}
                                  : {1'b0, tail} + WRAP_O - {1'b0, head};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (live && r_op == OP_PUSH) begin
                    n_state = S_PTR;
                end else if (live && r_op == OP_TAKE) begin
                    if (r_nonempty[w_ext[WBITS-1:0]]) begin
                        n_state = S_PTR;
                    end else if (n_ext > IDXW'(1)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (r_cnt >= n_ext) begin
                    n_state = S_RESULT;
                end else if (r_nonempty[r_v[WBITS-1:0]]) begin
                    n_state = S_PTR;
                end
            end
            S_PTR:    n_state = S_ACCESS;
            S_ACCESS: n_state = (r_op == OP_PUSH) ? S_RESULT : S_DATA;
            S_DATA:   n_state = S_RESULT;
            S_RESULT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_op        = r_op;
        n_w         = r_w;
        n_taddr     = r_taddr;
        n_tsize     = r_tsize;
        n_sel       = r_sel;
        n_v         = r_v;
        n_cnt       = r_cnt;
        n_steal     = r_steal;
        n_ok        = r_ok;
        n_full      = r_full;
        n_got_addr  = r_got_addr;
        n_got_size  = r_got_size;
        n_stolen    = r_stolen;
        n_victim    = r_victim;
        n_in_flight = r_in_flight;
        n_nonempty  = r_nonempty;
        ptr_we      = 1'b0;
        ptr_wdata   = {head, tail};
        dat_we      = 1'b0;
        dat_re      = 1'b0;
        dat_idx     = slot_addr(r_sel, tail);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_opcode;
                    n_w        = i_worker;
                    n_taddr    = i_task_addr[SABITS-1:0];
                    n_tsize    = i_task_size;
                    n_steal    = 1'b0;
                    n_ok       = 1'b0;
                    n_full     = 1'b0;
                    n_got_addr = '0;
                    n_got_size = '0;
                    n_stolen   = 1'b0;
                    n_victim   = '0;
                end
            end
            S_LOOK: begin
                n_sel = w_ext[WBITS-1:0];
                n_v   = (w_ext + 1'b1 == n_ext) ? '0 : w_ext + 1'b1;
                n_cnt = IDXW'(1);
                if (r_op == OP_COMPLETE && r_in_flight != '0) begin
                    n_in_flight = r_in_flight - 1'b1;
                end
            end
            S_SCAN: begin
                if (r_cnt < n_ext && r_nonempty[r_v[WBITS-1:0]]) begin
                    n_sel   = r_v[WBITS-1:0];
                    n_steal = 1'b1;
                end else begin
                    n_v   = (r_v + 1'b1 == n_ext) ? '0 : r_v + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACCESS: begin
                if (r_op == OP_PUSH) begin
                    if (occ >= QD_O) begin
                        n_full = 1'b1;
                    end else begin
                        dat_we            = 1'b1;
                        ptr_we            = 1'b1;
                        ptr_wdata         = {head, ptr_inc(tail)};
                        n_nonempty[r_sel] = 1'b1;
                        n_ok              = 1'b1;
                        if (r_in_flight != INFLIGHT_MAX) begin
                            n_in_flight = r_in_flight + 1'b1;
                        end
                    end
                end else if (!r_steal) begin
                    dat_re            = 1'b1;
                    dat_idx           = slot_addr(r_sel, ntail);
                    ptr_we            = 1'b1;
                    ptr_wdata         = {head, ntail};
                    n_nonempty[r_sel] = (ntail != head);
                    n_ok              = 1'b1;
                    n_victim          = r_w;
                end else begin
                    dat_re            = 1'b1;
                    dat_idx           = slot_addr(r_sel, head);
                    ptr_we            = 1'b1;
                    ptr_wdata         = {nhead, tail};
                    n_nonempty[r_sel] = (nhead != tail);
                    n_ok              = 1'b1;
                    n_stolen          = 1'b1;
                    n_victim          = r_v[WORKER_W-1:0];
                end
            end
            S_DATA: begin
                n_got_addr = TADDR_W'(r_rd_addr);
                n_got_size = r_rd_size;
            end
            S_PTR, S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_RESULT);
        o_ok        = r_ok;
        o_full_res  = r_full;
        o_got_addr  = r_got_addr;
        o_got_size  = r_got_size;
        o_stolen    = r_stolen;
        o_victim    = r_victim;
        o_all_done  = (r_in_flight == '0) && (r_nonempty == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_workers <= NUM_WORKERS_RST;
            r_in_flight   <= '0;
            r_nonempty    <= '0;
            r_pvalid      <= '0;
            r_steal       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_flight <= n_in_flight;
            r_nonempty  <= n_nonempty;
            r_steal     <= n_steal;
            if (i_cfg_we) begin
                r_num_workers <= i_cfg_data;
            end
            if (ptr_we) begin
                r_pvalid[r_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_w        <= n_w;
        r_taddr    <= n_taddr;
        r_tsize    <= n_tsize;
        r_sel      <= n_sel;
        r_v        <= n_v;
        r_cnt      <= n_cnt;
        r_ok       <= n_ok;
        r_full     <= n_full;
        r_got_addr <= n_got_addr;
        r_got_size <= n_got_size;
        r_stolen   <= n_stolen;
        r_victim   <= n_victim;
    end

    // head/tail pointer memory, entry valid bits give the zero reset value
    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            r_ptr_mem[r_sel] <= ptr_wdata;
        end
        r_ptr_q <= r_ptr_mem[r_sel];
        r_pv_q  <= r_pvalid[r_sel];
    end

    // task memory
    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            r_addr_mem[dat_idx] <= r_taddr;
            r_size_mem[dat_idx] <= r_tsize;
        end
        if (dat_re) begin
            r_rd_addr <= r_addr_mem[dat_idx];
            r_rd_size <= r_size_mem[dat_idx];
        end
    end

    a_ok_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_ok && o_full_res))
        else $error("ok and full both set");

    a_stolen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stolen) |-> (o_ok && !o_full_res))
        else $error("steal without task");

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PTR && r_op != OP_PUSH) |-> r_nonempty[r_sel])
        else $error("take from empty deque");

    a_valid_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nonempty & ~r_pvalid) == '0)
        else $error("non-empty deque without pointer entry");

    a_inflight_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_in_flight != $past(r_in_flight)) |->
            (r_in_flight == $past(r_in_flight) + 1'b1 ||
             r_in_flight == $past(r_in_flight) - 1'b1))
        else $error("in-flight count jumped");

endmodule
`default_nettype wire

@@ tb/tb_work_stealing_task_queues.sv @@
// Testbench for the work-stealing task queues: directed and random requests checked against a scheduler model.
`timescale 1ns / 1ps
module tb_work_stealing_task_queues;
    import wstq_pkg::*;

    localparam int NW = NUM_WORKERS_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int PTR_W = $clog2(2 * QD);
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [TSIZE_W-1:0] SIZE_ONE = TSIZE_W'(1);

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [WORKER_W-1:0] worker;
        logic [TADDR_W-1:0]  addr;
        logic [TSIZE_W-1:0]  size;
    } t_sched_req;

    typedef struct packed {
        logic                ok;
        logic                full_res;
        logic [TADDR_W-1:0]  got_addr;
        logic [TSIZE_W-1:0]  got_size;
        logic                stolen;
        logic [WORKER_W-1:0] victim;
        logic                all_done;
    } t_sched_res;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic [WORKER_W-1:0] i_worker = '0;
    logic [TADDR_W-1:0]  i_task_addr = '0;
    logic [TSIZE_W-1:0]  i_task_size = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_ok;
    logic                o_full_res;
    logic [TADDR_W-1:0]  o_got_addr;
    logic [TSIZE_W-1:0]  o_got_size;
    logic                o_stolen;
    logic [WORKER_W-1:0] o_victim;
    logic                o_all_done;

    work_stealing_task_queues uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_worker    (i_worker),
        .i_task_addr (i_task_addr),
        .i_task_size (i_task_size),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_full_res  (o_full_res),
        .o_got_addr  (o_got_addr),
        .o_got_size  (o_got_size),
        .o_stolen    (o_stolen),
        .o_victim    (o_victim),
        .o_all_done  (o_all_done)
    );

    always #5 i_clk = ~i_clk;

    // scheduler model state
    logic [TADDR_W-1:0]    task_addr_mem [NW*QD];
    logic [TSIZE_W-1:0]    task_size_mem [NW*QD];
    logic [PTR_W-1:0]      head_q [NW];
    logic [PTR_W-1:0]      tail_q [NW];
    logic [INFLIGHT_W-1:0] model_in_flight;
    logic [CFG_W-1:0]      worker_count_cfg;

    t_sched_req pending_reqs [$];
    t_sched_res expected_results [$];

    int err_count = 0;
    int offered = 0;
    int in_beats = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int stores = 0, drops = 0, own_takes = 0, steals = 0, empty_takes = 0;
    int idle_reports = 0, peak_in_flight = 0;

    function automatic logic [PTR_W-1:0] deque_fill(int w);
        return tail_q[w] - head_q[w];
    endfunction

    function automatic int active_workers();
        if (worker_count_cfg == 0) return 1;
        if (worker_count_cfg > NW) return NW;
        return worker_count_cfg;
    endfunction

    function automatic t_sched_res schedule_request(t_sched_req rq);
        t_sched_res r;
        int n, w, v, s, off, i;
        r = '0;
        n = active_workers();
        w = rq.worker;
        if (rq.op == OP_PUSH && w < n) begin
            if (deque_fill(w) >= QD) begin
                r.full_res = 1'b1;
                drops++;
            end else begin
                s = w * QD + tail_q[w] % QD;
                task_addr_mem[s] = rq.addr;
                task_size_mem[s] = rq.size;
                tail_q[w] = tail_q[w] + 1'b1;
                if (model_in_flight != INFLIGHT_MAX) model_in_flight++;
                r.ok = 1'b1;
                stores++;
            end
        end else if (rq.op == OP_TAKE && w < n) begin
            if (deque_fill(w) != 0) begin
                tail_q[w] = tail_q[w] - 1'b1;
                s = w * QD + tail_q[w] % QD;
                r.got_addr = task_addr_mem[s];
                r.got_size = task_size_mem[s];
                r.victim = WORKER_W'(w);
                r.ok = 1'b1;
                own_takes++;
            end else begin
                for (off = 1; off < n && !r.ok; off++) begin
                    v = (w + off) % n;
                    if (deque_fill(v) != 0) begin
                        s = v * QD + head_q[v] % QD;
                        r.got_addr = task_addr_mem[s];
                        r.got_size = task_size_mem[s];
                        head_q[v] = head_q[v] + 1'b1;
                        r.victim = WORKER_W'(v);
                        r.stolen = 1'b1;
                        r.ok = 1'b1;
                    end
                end
                if (r.ok) steals++;
                else empty_takes++;
            end
        end else if (rq.op == OP_COMPLETE) begin
            if (model_in_flight != 0) model_in_flight--;
        end
        r.all_done = (model_in_flight == 0);
        for (i = 0; i < NW; i++)
            if (deque_fill(i) != 0) r.all_done = 1'b0;
        if (r.all_done) idle_reports++;
        if (model_in_flight > peak_in_flight) peak_in_flight = model_in_flight;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // monitor: check result beats, predict on request beats
    always @(posedge i_clk) begin
        t_sched_res got_res, want_res;
        t_sched_req seen_req;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_res = {o_ok, o_full_res, o_got_addr, o_got_size, o_stolen, o_victim,
                           o_all_done};
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got_res);
                    err_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    compare_field("ok", want_res.ok, got_res.ok);
                    compare_field("full_res", want_res.full_res, got_res.full_res);
                    compare_field("got_addr", want_res.got_addr, got_res.got_addr);
                    compare_field("got_size", want_res.got_size, got_res.got_size);
                    compare_field("stolen", want_res.stolen, got_res.stolen);
                    compare_field("victim", want_res.victim, got_res.victim);
                    compare_field("all_done", want_res.all_done, got_res.all_done);
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen_req = {i_opcode, i_worker, i_task_addr, i_task_size};
                expected_results.push_back(schedule_request(seen_req));
                in_beats++;
            end
        end
    end

    // driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_sched_req rq;
        if (i_rst_n && !(i_in_valid && in_beats != offered)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                i_opcode <= rq.op;
                i_worker <= rq.worker;
                i_task_addr <= rq.addr;
                i_task_size <= rq.size;
                i_in_valid <= 1'b1;
                offered++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(40, 1);
                    case ($urandom_range(3, 0))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(40, 10);
                        default: gap_left = $urandom_range(6, 1);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns plus one long hold-off
    t_rx_mode rx_mode = RX_STEADY;
    int rx_mode_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(2, 0));
                rx_mode_left = $urandom_range(200, 20);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_STEADY: i_out_ready <= 1'b1;
                RX_COIN: i_out_ready <= 1'($urandom_range(1, 0));
                default: i_out_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [TADDR_W-1:0] rand_addr();
        return TADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TSIZE_W-1:0] rand_size();
        case ($urandom_range(9, 0))
            0: return SIZE_ONE;
            1: return '1;
            default: return TSIZE_W'($urandom_range(32'h7FFF_FFFF, 1));
        endcase
    endfunction

    task automatic add_req(input logic [OPCODE_W-1:0] op, input int w,
                           input logic [TADDR_W-1:0] a, input logic [TSIZE_W-1:0] s);
        t_sched_req rq;
        rq.op = op;
        rq.worker = WORKER_W'(w);
        rq.addr = a;
        rq.size = s;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || in_beats != offered || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_worker_count(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        worker_count_cfg = v;
        @(posedge i_clk);
    endtask

    task automatic add_random_phase(input int count, input int push_pct, input int take_pct,
                                    input int done_pct);
        logic [OPCODE_W-1:0] op;
        int roll, n, w;
        n = active_workers();
        repeat (count) begin
            roll = $urandom_range(99, 0);
            if (roll < push_pct) op = OP_PUSH;
            else if (roll < push_pct + take_pct) op = OP_TAKE;
            else if (roll < push_pct + take_pct + done_pct) op = OP_COMPLETE;
            else op = OP_NONE;
            w = ($urandom_range(99, 0) < 85) ? $urandom_range(n - 1, 0) : $urandom_range(NW - 1, 0);
            add_req(op, w, rand_addr(), rand_size());
        end
    endtask

    initial begin
        int fill_w, fill_n, i;
        foreach (head_q[k]) begin
            head_q[k] = '0;
            tail_q[k] = '0;
        end
        model_in_flight = '0;
        worker_count_cfg = NUM_WORKERS_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_req(OP_COMPLETE, 0, '0, SIZE_ONE);          // complete with nothing in flight
        add_req(OP_NONE, 15, '1, '1);
        add_req(OP_TAKE, 3, '0, SIZE_ONE);              // nothing anywhere
        add_req(OP_PUSH, 0, '0, SIZE_ONE);
        add_req(OP_PUSH, 0, '1, '1);
        add_req(OP_PUSH, 15, 48'h5555_5555_5555, 31'h2AAA_AAAA);
        add_req(OP_TAKE, 0, '0, SIZE_ONE);              // own tail, newest first
        add_req(OP_TAKE, 0, '0, SIZE_ONE);
        add_req(OP_TAKE, 0, '0, SIZE_ONE);              // steal from the far end of the scan
        add_req(OP_TAKE, 15, '0, SIZE_ONE);
        add_req(OP_PUSH, 7, 48'hAAAA_AAAA_AAAA, 31'h5555_5555);
        add_req(OP_TAKE, 8, '1, '1);                    // scan wraps around to 7
        add_req(OP_COMPLETE, 2, '0, SIZE_ONE);
        add_req(OP_COMPLETE, 9, '0, SIZE_ONE);
        add_req(OP_COMPLETE, 15, '0, SIZE_ONE);
        add_req(OP_COMPLETE, 0, '0, SIZE_ONE);          // back to idle

        set_worker_count(5'd0);                         // acts as one worker
        add_req(OP_PUSH, 1, rand_addr(), rand_size());  // inactive worker
        add_req(OP_TAKE, 1, '0, SIZE_ONE);
        add_req(OP_PUSH, 0, rand_addr(), rand_size());
        add_req(OP_COMPLETE, 5, '0, SIZE_ONE);          // inactive complete still counts
        add_req(OP_TAKE, 0, '0, SIZE_ONE);

        set_worker_count(5'd31);                        // clamps to all workers
        add_req(OP_PUSH, 15, rand_addr(), rand_size());
        add_req(OP_TAKE, 14, '0, SIZE_ONE);

        set_worker_count(5'd2);  add_random_phase(145, 70, 20, 8);
        set_worker_count(5'd1);  add_random_phase(145, 75, 15, 8);
        set_worker_count(5'd16); add_random_phase(145, 30, 55, 12);
        set_worker_count(5'd5);  add_random_phase(145, 45, 35, 17);
        set_worker_count(5'd0);  add_random_phase(145, 40, 45, 12);
        set_worker_count(5'd31); add_random_phase(145, 50, 30, 17);
        set_worker_count(5'd17); add_random_phase(145, 20, 50, 27);
        set_worker_count(5'd16); add_random_phase(145, 15, 45, 37);

        // fill two deques to the brim, push once more into each, then drain a few
        set_worker_count(5'd16);
        for (i = 0; i < 2; i++) begin
            fill_w = (i == 0) ? 3 : 12;
            fill_n = QD - int'(deque_fill(fill_w));
            repeat (fill_n) add_req(OP_PUSH, fill_w, rand_addr(), rand_size());
            add_req(OP_PUSH, fill_w, rand_addr(), rand_size());
        end
        for (i = 0; i < 8; i++) add_req(OP_TAKE, i, rand_addr(), rand_size());
        repeat (3) add_req(OP_COMPLETE, $urandom_range(NW - 1, 0), '0, SIZE_ONE);

        wait_drained();
        $display("covered %0d requests: %0d pushes stored, %0d dropped on full, %0d own takes",
                 in_beats, stores, drops, own_takes);
        $display("  %0d steals, %0d empty takes, %0d idle reports, in-flight peak %0d",
                 steals, empty_takes, idle_reports, peak_in_flight);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
